// ===== rtl/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg
// shared types and constants for the field sensor conditioner
// ----------------------------------------------------------------------------
package fsc_pkg;

  // configuration registers and result fields are fixed at 12 bits
  localparam int REG_W    = 12;
  localparam int OUT_W    = 12;
  localparam int IDX_W    = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TRACK_ENTRY = 3'd0;
  localparam logic [IDX_W-1:0] REG_TRACK_EXIT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_TRACK_START = 3'd2;
  localparam logic [IDX_W-1:0] REG_CROSS_ENTRY = 3'd3;
  localparam logic [IDX_W-1:0] REG_CROSS_EXIT  = 3'd4;
  localparam logic [IDX_W-1:0] REG_CROSS_START = 3'd5;

  // reset values
  localparam logic [REG_W-1:0] RST_TRACK_ENTRY = 12'd100;
  localparam logic [REG_W-1:0] RST_TRACK_EXIT  = 12'd50;
  localparam logic [REG_W-1:0] RST_TRACK_START = 12'd4095;
  localparam logic [REG_W-1:0] RST_CROSS_ENTRY = 12'd80;
  localparam logic [REG_W-1:0] RST_CROSS_EXIT  = 12'd40;
  localparam logic [REG_W-1:0] RST_CROSS_START = 12'd4095;

  // detection levels for one channel
  typedef struct packed {
    logic [REG_W-1:0] entry_level;
    logic [REG_W-1:0] exit_level;
    logic [REG_W-1:0] startup_min;
  } fsc_levels_t;

endpackage

// ===== rtl/fsc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fsc_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module fsc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [fsc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [fsc_pkg::REG_W-1:0]   cfg_data,
  output fsc_pkg::fsc_levels_t        track_levels,
  output fsc_pkg::fsc_levels_t        cross_levels
);
  import fsc_pkg::*;

  fsc_levels_t track_r, cross_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r.entry_level <= RST_TRACK_ENTRY;
      track_r.exit_level  <= RST_TRACK_EXIT;
      track_r.startup_min <= RST_TRACK_START;
      cross_r.entry_level <= RST_CROSS_ENTRY;
      cross_r.exit_level  <= RST_CROSS_EXIT;
      cross_r.startup_min <= RST_CROSS_START;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TRACK_ENTRY: track_r.entry_level <= cfg_data;
        REG_TRACK_EXIT:  track_r.exit_level  <= cfg_data;
        REG_TRACK_START: track_r.startup_min <= cfg_data;
        REG_CROSS_ENTRY: cross_r.entry_level <= cfg_data;
        REG_CROSS_EXIT:  cross_r.exit_level  <= cfg_data;
        REG_CROSS_START: cross_r.startup_min <= cfg_data;
        default: ; // unknown index, ignored
      endcase
    end
  end

  assign track_levels = track_r;
  assign cross_levels = cross_r;

endmodule

// ===== rtl/fsc_channel.sv =====
// ----------------------------------------------------------------------------
// fsc_channel
// one channel: smoothing filter, tracking baseline and hysteresis detect
// ----------------------------------------------------------------------------
module fsc_channel #(
  parameter int ADC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  fast_track,
  input  logic [ADC_BITS-1:0]   sample,
  input  fsc_pkg::fsc_levels_t  levels,
  output logic [ADC_BITS-1:0]   smoothed_nxt,
  output logic [ADC_BITS-1:0]   strength,
  output logic                  present_nxt
);
  import fsc_pkg::*;

  localparam int CW = (ADC_BITS > REG_W) ? ADC_BITS : REG_W;

  logic [ADC_BITS-1:0] smoothed_r, baseline_r, baseline_nxt;
  logic                present_r;

  logic [ADC_BITS+1:0] smooth_sum;
  logic [ADC_BITS+3:0] base_ext, smooth_ext, fast_sum, slow_sum;
  logic [ADC_BITS-1:0] base_blend, strength_pre;
  logic                present_pre;

  function automatic logic [ADC_BITS-1:0] abs_diff(input logic [ADC_BITS-1:0] a,
                                                   input logic [ADC_BITS-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic decide(input logic was, input logic [ADC_BITS-1:0] st,
                                  input logic [ADC_BITS-1:0] sm, input fsc_levels_t lv);
    logic [CW-1:0] st_x, sm_x, en_x, ex_x, su_x;
    st_x = CW'(st);
    sm_x = CW'(sm);
    en_x = CW'(lv.entry_level);
    ex_x = CW'(lv.exit_level);
    su_x = CW'(lv.startup_min);
    if (was) decide = (st_x >= ex_x);
    else     decide = (st_x >= en_x) || (sm_x >= su_x);
  endfunction

  // (3*old + sample) / 4
  assign smooth_sum   = {smoothed_r, 1'b0} + {2'b00, smoothed_r} + {2'b00, sample};
  assign smoothed_nxt = smooth_sum[ADC_BITS+1:2];

  assign strength_pre = abs_diff(smoothed_nxt, baseline_r);
  assign present_pre  = decide(present_r, strength_pre, smoothed_nxt, levels);

  // (7*b + s) / 8 while settling, (15*b + s) / 16 after
  assign base_ext   = {4'b0000, baseline_r};
  assign smooth_ext = {4'b0000, smoothed_nxt};
  assign fast_sum   = (base_ext << 3) - base_ext + smooth_ext;
  assign slow_sum   = (base_ext << 4) - base_ext + smooth_ext;
  assign base_blend = fast_track ? fast_sum[ADC_BITS+2:3] : slow_sum[ADC_BITS+3:4];

  assign baseline_nxt = present_pre ? baseline_r : base_blend;
  assign strength     = abs_diff(smoothed_nxt, baseline_nxt);
  assign present_nxt  = decide(present_r, strength, smoothed_nxt, levels);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r <= '0;
      baseline_r <= '0;
      present_r  <= 1'b0;
    end else if (accept) begin
      smoothed_r <= smoothed_nxt;
      baseline_r <= baseline_nxt;
      present_r  <= present_nxt;
    end
  end

endmodule

// ===== rtl/field_sensor_conditioner_unit.sv =====
// ----------------------------------------------------------------------------
// field_sensor_conditioner_unit
// three channel field detector conditioning with hysteresis presence flags
// ----------------------------------------------------------------------------
// usage
//   input beat: one triple of adc samples (left, right, intersection), taken
//   when in_valid is high and in_stall is low
//   output beat: smoothed value, strength and present flag for each channel,
//   taken when out_valid is high and out_stall is low
//   out_valid is registered and is set in the cycle after the accepted input beat
//   throughput: one beat per cycle while in_stall is low; the channel state updates and the
//   result register loads in the same cycle as the input beat is taken
//   the result register parts the two sides: a new beat is taken while the
//   held result is being taken in the same cycle
//   when the receiver stalls a full result register, in_stall is raised and
//   the result holds unchanged
//   reset (rst_n low, synchronous) clears filters, baselines, flags and the
//   settle counter and restores the configuration registers to their defaults
//   configuration writes are single cycle on cfg_wr_en, index beyond the
//   register list is ignored; write only while no beat is in flight
// ----------------------------------------------------------------------------
module field_sensor_conditioner_unit #(
  parameter int ADC_BITS       = 12,
  parameter int SETTLE_SAMPLES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [fsc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [fsc_pkg::REG_W-1:0]  cfg_data,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ADC_BITS-1:0]        in_left_sample,
  input  logic [ADC_BITS-1:0]        in_right_sample,
  input  logic [ADC_BITS-1:0]        in_cross_sample,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fsc_pkg::OUT_W-1:0]  out_left_smoothed,
  output logic [fsc_pkg::OUT_W-1:0]  out_left_strength,
  output logic                       out_left_present,
  output logic [fsc_pkg::OUT_W-1:0]  out_right_smoothed,
  output logic [fsc_pkg::OUT_W-1:0]  out_right_strength,
  output logic                       out_right_present,
  output logic [fsc_pkg::OUT_W-1:0]  out_cross_smoothed,
  output logic [fsc_pkg::OUT_W-1:0]  out_cross_strength,
  output logic                       out_cross_present
);
  import fsc_pkg::*;

  localparam int CNT_W = $clog2(SETTLE_SAMPLES + 1);
  localparam logic [CNT_W-1:0] SETTLE_CNT = CNT_W'(SETTLE_SAMPLES);

  fsc_levels_t track_levels, cross_levels;

  logic               in_accept;
  logic               fast_track;
  logic [CNT_W-1:0]   count_r;
  logic               out_valid_r, out_valid_nxt;

  logic [ADC_BITS-1:0] l_smooth, l_str, r_smooth, r_str, x_smooth, x_str;
  logic                l_pres, r_pres, x_pres;

  // result register payload
  logic [OUT_W-1:0] l_smooth_r, l_str_r, r_smooth_r, r_str_r, x_smooth_r, x_str_r;
  logic             l_pres_r, r_pres_r, x_pres_r;

  // stall only when the held result cannot leave this cycle
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // fast baseline tracking until the settle count is reached
  assign fast_track = (count_r < SETTLE_CNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_accept && fast_track) begin
      count_r <= count_r + 1'b1;
    end
  end

  fsc_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .track_levels (track_levels),
    .cross_levels (cross_levels)
  );

  // left and right share the track levels, intersection has its own
  fsc_channel #(.ADC_BITS(ADC_BITS)) u_left (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .fast_track   (fast_track),
    .sample       (in_left_sample),
    .levels       (track_levels),
    .smoothed_nxt (l_smooth),
    .strength     (l_str),
    .present_nxt  (l_pres)
  );

  fsc_channel #(.ADC_BITS(ADC_BITS)) u_right (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .fast_track   (fast_track),
    .sample       (in_right_sample),
    .levels       (track_levels),
    .smoothed_nxt (r_smooth),
    .strength     (r_str),
    .present_nxt  (r_pres)
  );

  fsc_channel #(.ADC_BITS(ADC_BITS)) u_cross (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .fast_track   (fast_track),
    .sample       (in_cross_sample),
    .levels       (cross_levels),
    .smoothed_nxt (x_smooth),
    .strength     (x_str),
    .present_nxt  (x_pres)
  );

  // result register valid
  always_comb begin
    if (in_accept)       out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, loaded on every accepted beat; results keep the low 12 bits
  always_ff @(posedge clk) begin
    if (in_accept) begin
      l_smooth_r <= OUT_W'(l_smooth);
      l_str_r    <= OUT_W'(l_str);
      l_pres_r   <= l_pres;
      r_smooth_r <= OUT_W'(r_smooth);
      r_str_r    <= OUT_W'(r_str);
      r_pres_r   <= r_pres;
      x_smooth_r <= OUT_W'(x_smooth);
      x_str_r    <= OUT_W'(x_str);
      x_pres_r   <= x_pres;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_smoothed  = l_smooth_r;
  assign out_left_strength  = l_str_r;
  assign out_left_present   = l_pres_r;
  assign out_right_smoothed = r_smooth_r;
  assign out_right_strength = r_str_r;
  assign out_right_present  = r_pres_r;
  assign out_cross_smoothed = x_smooth_r;
  assign out_cross_strength = x_str_r;
  assign out_cross_present  = x_pres_r;

endmodule

// ===== rtl/fsc_checker.sv =====
// ----------------------------------------------------------------------------
// fsc_checker
// port level checks for the field sensor conditioner, bound to the top level
// ----------------------------------------------------------------------------
module fsc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [fsc_pkg::OUT_W-1:0]  out_left_smoothed,
  input logic [fsc_pkg::OUT_W-1:0]  out_right_smoothed,
  input logic [fsc_pkg::OUT_W-1:0]  out_cross_smoothed,
  input logic                       out_left_present
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_smoothed) &&
      $stable(out_right_smoothed) && $stable(out_cross_smoothed) &&
      $stable(out_left_present))
    else $error("stalled result changed");

  // accepted beat gives a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  // input stalls only behind a stalled full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // a new result only follows an accepted beat
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an input beat");

endmodule

bind field_sensor_conditioner_unit fsc_checker u_fsc_checker (.*);
